@@ sv/aec_pkg.sv @@
// Shared types, codes and sizes for the ALOHA event channel simulator.
package aec_pkg;

    localparam int TIME_W      = 48;
    localparam int CNT_W       = 32;
    localparam int DELAY_W     = 32;
    localparam int QUEUE_DEPTH = 32;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QADDR_W + 1;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] OP_SEED    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_ARRIVAL = 2'd1;
    localparam logic [1:0] KIND_SUCCESS = 2'd2;
    localparam logic [1:0] KIND_COLLIDE = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd1;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [1:0]         op;
        logic [DELAY_W-1:0] delay;
    } in_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] clock_now;
        logic [1:0]        event_kind;
        logic [CNT_W-1:0]  attempt_total;
        logic [CNT_W-1:0]  success_total;
        logic [CNT_W-1:0]  collision_total;
        logic [1:0]        status;
        logic              past_limit;
    } out_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] etime;
        logic              is_tx_end;
        logic              collided;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_DAT,
        S_MK_RD,
        S_MK_DAT,
        S_INS_SET,
        S_INS_RD,
        S_INS_DAT,
        S_FIN
    } state_t;

endpackage

@@ sv/aec_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module aec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/aec_ctrl.sv @@
// Event sequencer: pops, inserts and marks queue entries held in the RAM.
module aec_ctrl import aec_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_word,
    input  logic [31:0]       frame_time,
    input  logic [TIME_W-1:0] time_limit,
    output logic              res_valid,
    input  logic              res_ready,
    output out_word_t         res_word
);

    state_t state_reg, state_next;
    logic [QADDR_W-1:0] head_reg, head_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QCNT_W-1:0]  k_reg, k_next;
    logic [TIME_W-1:0]  clock_reg, clock_next;
    logic [CNT_W-1:0]   att_reg, att_next, suc_reg, suc_next, col_reg, col_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [TIME_W-1:0]  ins_time_reg, ins_time_next;
    logic               second_reg, second_next;
    logic               hit_reg, hit_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         status_reg, status_next;

    logic               wr_en;
    logic [QADDR_W-1:0] wr_addr, rd_addr;
    entry_t             wr_data, rd_data;

    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  sum_sat;
    logic [CNT_W-1:0]   att_fin, suc_fin, col_fin;

    aec_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            clock_reg  <= '0;
            att_reg    <= '0;
            suc_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            clock_reg  <= clock_next;
            att_reg    <= att_next;
            suc_reg    <= suc_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        delay_reg    <= delay_next;
        ins_time_reg <= ins_time_next;
        second_reg   <= second_next;
        hit_reg      <= hit_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
    end

    // The new time saturates at the top of the 48-bit range.
    always_comb
    begin
        sum     = {1'b0, clock_reg}
                + {{(TIME_W + 1 - DELAY_W){1'b0}}, (second_reg ? delay_reg : frame_time)};
        sum_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    end

    always_comb
    begin
        att_fin = att_reg;
        suc_fin = suc_reg;
        col_fin = col_reg;
        case (kind_reg)
            KIND_ARRIVAL: att_fin = (att_reg == CNT_MAX) ? att_reg : att_reg + 1'b1;
            KIND_SUCCESS: suc_fin = (suc_reg == CNT_MAX) ? suc_reg : suc_reg + 1'b1;
            KIND_COLLIDE: col_fin = (col_reg == CNT_MAX) ? col_reg : col_reg + 1'b1;
            default: ;
        endcase
        res_word.clock_now       = clock_reg;
        res_word.event_kind      = kind_reg;
        res_word.attempt_total   = att_fin;
        res_word.success_total   = suc_fin;
        res_word.collision_total = col_fin;
        res_word.status          = status_reg;
        res_word.past_limit      = clock_reg > time_limit;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        clock_next    = clock_reg;
        att_next      = att_reg;
        suc_next      = suc_reg;
        col_next      = col_reg;
        delay_next    = delay_reg;
        ins_time_next = ins_time_reg;
        second_next   = second_reg;
        hit_next      = hit_reg;
        kind_next     = kind_reg;
        status_next   = status_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = head_reg + k_reg[QADDR_W-1:0];
        wr_data       = rd_data;
        rd_addr       = head_reg + k_reg[QADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    delay_next  = in_word.delay;
                    kind_next   = KIND_NONE;
                    status_next = STAT_OK;
                    second_next = 1'b1;
                    case (in_word.op)
                        OP_SEED:    state_next = S_INS_SET;
                        OP_ADVANCE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            clock_next = '0;
                            att_next   = '0;
                            suc_next   = '0;
                            col_next   = '0;
                            state_next = S_FIN;
                        end
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_POP_RD:
            begin
                rd_addr    = head_reg;
                state_next = S_POP_DAT;
            end
            S_POP_DAT:
            begin
                clock_next = rd_data.etime;
                head_next  = head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                k_next     = '0;
                if (!rd_data.is_tx_end)
                begin
                    kind_next   = KIND_ARRIVAL;
                    second_next = 1'b0;
                    state_next  = S_INS_SET;
                end
                else
                begin
                    hit_next   = rd_data.collided;
                    state_next = S_MK_RD;
                end
            end
            S_MK_RD:
            begin
                if (k_reg == count_reg)
                begin
                    kind_next  = hit_reg ? KIND_COLLIDE : KIND_SUCCESS;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MK_DAT;
                end
            end
            S_MK_DAT:
            begin
                // Every pending transmission overlaps the one that just ended.
                if (rd_data.is_tx_end)
                begin
                    wr_en            = 1'b1;
                    wr_data.collided = 1'b1;
                    hit_next         = 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = S_MK_RD;
            end
            S_INS_SET:
            begin
                if (count_reg == QCNT_W'(QUEUE_DEPTH))
                begin
                    status_next = STAT_FULL;
                    second_next = 1'b1;
                    state_next  = second_reg ? S_FIN : S_INS_SET;
                end
                else
                begin
                    ins_time_next = sum_sat;
                    k_next        = count_reg;
                    state_next    = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                rd_addr = head_reg + k_reg[QADDR_W-1:0] - 1'b1;
                if (k_reg == '0)
                begin
                    wr_en       = 1'b1;
                    wr_data     = '{etime: ins_time_reg, is_tx_end: !second_reg, collided: 1'b0};
                    count_next  = count_reg + 1'b1;
                    second_next = 1'b1;
                    state_next  = second_reg ? S_FIN : S_INS_SET;
                end
                else
                begin
                    state_next = S_INS_DAT;
                end
            end
            S_INS_DAT:
            begin
                // Entries at or after the new time move one place back.
                wr_en = 1'b1;
                if (rd_data.etime >= ins_time_reg)
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    wr_data     = '{etime: ins_time_reg, is_tx_end: !second_reg, collided: 1'b0};
                    count_next  = count_reg + 1'b1;
                    second_next = 1'b1;
                    state_next  = second_reg ? S_FIN : S_INS_SET;
                end
            end
            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    att_next   = att_fin;
                    suc_next   = suc_fin;
                    col_next   = col_fin;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ sv/aloha_event_channel_sim.sv @@
// Top level: configuration registers, event sequencer and output word register.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------
//   in        | in_valid / in_ready  | in_word (op, delay)
//   out       | out_valid / out_ready| out_word (clock, kind, totals)
//   cfg       | cfg_en               | cfg_index, cfg_data
//
// One word is processed at a time. Every queue entry touched costs a read state and a data
// state on the single-read-port queue RAM, so a seed, an arrival and a transmit end take
// longer the more entries the queue holds.
// Reset empties the queue by its count; RAM contents are left as they are.
// A finished word waits in the output register while the next input word is taken.
module aloha_event_channel_sim import aec_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_word,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [31:0]       frame_time_reg;
    logic [TIME_W-1:0] time_limit_reg;
    logic              out_valid_reg;
    out_word_t         out_word_reg;
    logic              res_valid, res_ready;
    out_word_t         res_word;

    assign res_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    aec_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .frame_time (frame_time_reg),
        .time_limit (time_limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg <= 32'd65536;
            time_limit_reg <= 48'd6553600;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_en && cfg_index == REG_FRAME_TIME)
            begin
                frame_time_reg <= cfg_data[31:0];
            end
            if (cfg_en && cfg_index == REG_TIME_LIMIT)
            begin
                time_limit_reg <= cfg_data[TIME_W-1:0];
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res_word;
        end
    end

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input word accepted while another is in progress");

    a_empty_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status == STAT_EMPTY |-> out_word.event_kind == KIND_NONE)
        else $error("empty queue reported an event");

    a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(cfg_en) |->
            out_word.past_limit == (out_word.clock_now > time_limit_reg))
        else $error("past_limit disagrees with clock");
`endif

endmodule
